[hdl/mdio_pkg.sv]
// Shared types and constants for the multiply/divide I/O register block.
package mdio_pkg;

  // Access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Register offsets within the 32-byte page.
  localparam logic [4:0] OFF_IO_PORT   = 5'h01;
  localparam logic [4:0] OFF_MCAND     = 5'h02;
  localparam logic [4:0] OFF_MUL_START = 5'h03;
  localparam logic [4:0] OFF_DVND_LO   = 5'h04;
  localparam logic [4:0] OFF_DVND_HI   = 5'h05;
  localparam logic [4:0] OFF_DIV_START = 5'h06;
  localparam logic [4:0] OFF_FAST_SEL  = 5'h0D;
  localparam logic [4:0] OFF_QUO_LO    = 5'h14;
  localparam logic [4:0] OFF_QUO_HI    = 5'h15;
  localparam logic [4:0] OFF_PRR_LO    = 5'h16;
  localparam logic [4:0] OFF_PRR_HI    = 5'h17;

  // Last step indices of the shared adder: one bit per cycle.
  localparam logic [3:0] MUL_LAST_STEP = 4'd7;
  localparam logic [3:0] DIV_LAST_STEP = 4'd15;

  // Value left in the quotient by a divide by zero.
  localparam logic [15:0] DIV_ZERO_QUO = 16'hFFFF;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } state_t;

  // One bus access.
  typedef struct packed {
    logic       opcode;
    logic [4:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] open_bus_byte;
  } request_t;

  // Result of one bus access.
  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] io_port_out;
    logic       fast_mem_select;
  } result_t;

endpackage

[hdl/mul_div_io_registers.sv]
// Multiply/divide I/O register block with one shared adder under a small sequencer.
// A read or a simple write gives its result in the cycle after the request.
// A multiply start gives it after 8 adder steps, a divide start by a nonzero divisor after
// 16 restoring steps; busy is high during the steps.
// The next request is taken in the cycle the result is strobed; the receiver cannot stall.
// Reset (rst, synchronous) restores the architectural registers and idles the sequencer.
module mul_div_io_registers
  import mdio_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  // Control and architectural registers.
  state_t      state, state_next;
  logic [3:0]  count, count_next;
  logic        done_next;
  result_t     result_next;
  logic [7:0]  io_port_reg, io_port_reg_next;
  logic [7:0]  multiplicand_reg, multiplicand_reg_next;
  logic [15:0] product_remainder_reg, product_remainder_reg_next;
  logic [15:0] dividend_reg, dividend_reg_next;
  logic [15:0] quotient_reg, quotient_reg_next;
  logic        fast_select_reg, fast_select_reg_next;
  logic [7:0]  divisor, divisor_next;
  logic [7:0]  bus_hold, bus_hold_next;

  // Shared adder.
  logic [8:0]  alu_a, alu_b;
  logic        alu_cin;
  logic [9:0]  alu_sum;

  logic        accept;
  logic        is_write;
  logic        mul_go, div_go;
  logic [8:0]  div_trial;
  logic [7:0]  rd_byte;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign is_write = (request.opcode == OP_WRITE);
  assign mul_go   = accept && is_write && (request.reg_offset == OFF_MUL_START);
  assign div_go   = accept && is_write && (request.reg_offset == OFF_DIV_START)
                    && (request.write_data != 8'd0);

  // Partial remainder with the next dividend bit shifted in.
  assign div_trial = {product_remainder_reg[7:0], quotient_reg[15]};

  // Operand selection for the shared adder: add the multiplicand or subtract the divisor.
  always_comb begin
    if (state == ST_DIV) begin
      alu_a   = div_trial;
      alu_b   = ~{1'b0, divisor};
      alu_cin = 1'b1;
    end else begin
      alu_a   = {1'b0, product_remainder_reg[15:8]};
      alu_b   = product_remainder_reg[0] ? {1'b0, multiplicand_reg} : 9'd0;
      alu_cin = 1'b0;
    end
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {9'd0, alu_cin};

  // Read decode.
  always_comb begin
    case (request.reg_offset)
      OFF_QUO_LO: rd_byte = quotient_reg[7:0];
      OFF_QUO_HI: rd_byte = quotient_reg[15:8];
      OFF_PRR_LO: rd_byte = product_remainder_reg[7:0];
      OFF_PRR_HI: rd_byte = product_remainder_reg[15:8];
      default:    rd_byte = request.open_bus_byte;
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Architectural registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      io_port_reg           <= 8'hFF;
      multiplicand_reg      <= 8'hFF;
      product_remainder_reg <= 16'hFFFF;
      dividend_reg          <= 16'hFFFF;
      quotient_reg          <= 16'hFFFF;
      fast_select_reg       <= 1'b0;
    end else begin
      io_port_reg           <= io_port_reg_next;
      multiplicand_reg      <= multiplicand_reg_next;
      product_remainder_reg <= product_remainder_reg_next;
      dividend_reg          <= dividend_reg_next;
      quotient_reg          <= quotient_reg_next;
      fast_select_reg       <= fast_select_reg_next;
    end
  end

  // Working registers and the result register need no reset.
  always_ff @(posedge clk) begin
    count    <= count_next;
    divisor  <= divisor_next;
    bus_hold <= bus_hold_next;
    result   <= result_next;
  end

  // Next state, register updates and result formation.
  always_comb begin
    state_next                 = state;
    count_next                 = count;
    done_next                  = 1'b0;
    result_next                = result;
    io_port_reg_next           = io_port_reg;
    multiplicand_reg_next      = multiplicand_reg;
    product_remainder_reg_next = product_remainder_reg;
    dividend_reg_next          = dividend_reg;
    quotient_reg_next          = quotient_reg;
    fast_select_reg_next       = fast_select_reg;
    divisor_next               = divisor;
    bus_hold_next              = bus_hold;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          bus_hold_next = request.open_bus_byte;
          if (mul_go) begin
            // Low byte holds the multiplier, high byte accumulates.
            product_remainder_reg_next = {8'd0, request.write_data};
            count_next                 = MUL_LAST_STEP;
            state_next                 = ST_MUL;
          end else if (div_go) begin
            // Quotient register shifts the dividend out and quotient bits in.
            product_remainder_reg_next = 16'd0;
            quotient_reg_next          = dividend_reg;
            divisor_next               = request.write_data;
            count_next                 = DIV_LAST_STEP;
            state_next                 = ST_DIV;
          end else begin
            if (is_write) begin
              case (request.reg_offset)
                OFF_IO_PORT:   io_port_reg_next      = request.write_data;
                OFF_MCAND:     multiplicand_reg_next = request.write_data;
                OFF_DVND_LO:   dividend_reg_next[7:0]  = request.write_data;
                OFF_DVND_HI:   dividend_reg_next[15:8] = request.write_data;
                OFF_DIV_START: begin
                  // Divide by zero.
                  quotient_reg_next          = DIV_ZERO_QUO;
                  product_remainder_reg_next = dividend_reg;
                end
                OFF_FAST_SEL:  fast_select_reg_next = request.write_data[0];
                default:       ;
              endcase
            end
            done_next                   = 1'b1;
            result_next.read_data       = is_write ? request.open_bus_byte : rd_byte;
            result_next.io_port_out     = io_port_reg_next;
            result_next.fast_mem_select = fast_select_reg_next;
          end
        end
      end

      ST_MUL: begin
        // Add the multiplicand when the multiplier bit is set, then shift right.
        product_remainder_reg_next = {alu_sum[8:0], product_remainder_reg[7:1]};
        count_next = count - 4'd1;
        if (count == 4'd0) begin
          state_next = ST_IDLE;
        end
      end

      ST_DIV: begin
        // Restoring step: keep the difference when it does not go negative.
        if (alu_sum[9]) begin
          product_remainder_reg_next = {8'd0, alu_sum[7:0]};
        end else begin
          product_remainder_reg_next = {8'd0, div_trial[7:0]};
        end
        quotient_reg_next = {quotient_reg[14:0], alu_sum[9]};
        count_next = count - 4'd1;
        if (count == 4'd0) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Finishing arithmetic step reports the write's result.
    if (state != ST_IDLE && count == 4'd0) begin
      done_next                   = 1'b1;
      result_next.read_data       = bus_hold;
      result_next.io_port_out     = io_port_reg;
      result_next.fast_mem_select = fast_select_reg;
    end
  end

  // A result is never strobed while a sequence is still running.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while busy");

  // Requests that need no arithmetic answer in the next cycle.
  a_simple_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && !mul_go && !div_go) |=> (done && !busy))
    else $error("simple request did not finish in one cycle");

  // A multiply takes eight adder steps.
  a_mul_latency: assert property (@(posedge clk) disable iff (rst)
    mul_go |-> ##9 done)
    else $error("multiply result late or missing");

  // A divide takes sixteen adder steps.
  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    div_go |-> ##17 done)
    else $error("divide result late or missing");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the multiply/divide I/O register block.
module testbench
  import mdio_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Offsets that map to nothing. They are used to exercise open-bus reads.
  localparam logic [4:0] OFF_UNMAPPED_LO = 5'h00;
  localparam logic [4:0] OFF_UNMAPPED_HI = 5'h1F;
  localparam int         RANDOM_ACCESSES = 1750;
  localparam int         SETTLE_CYCLES   = 24;

  // Predicts each access result from its own copy of the register file.
  class register_model;
    logic [7:0]  io_port;
    logic [7:0]  multiplicand;
    logic [15:0] product_remainder;
    logic [15:0] dividend;
    logic [15:0] quotient;
    logic        fast_select;
    result_t     pending_results[$];
    int          errors;

    function new();
      io_port           = 8'hFF;
      multiplicand      = 8'hFF;
      product_remainder = 16'hFFFF;
      dividend          = 16'hFFFF;
      quotient          = 16'hFFFF;
      fast_select       = 1'b0;
      errors            = 0;
    endfunction

    // Applies one accepted request and queues the result it should give.
    function void note_access(request_t req);
      result_t    predicted;
      logic [7:0] data;
      data                = req.write_data;
      predicted.read_data = req.open_bus_byte;
      if (req.opcode == OP_WRITE) begin
        case (req.reg_offset)
          OFF_IO_PORT:   io_port = data;
          OFF_MCAND:     multiplicand = data;
          OFF_MUL_START: product_remainder = {8'h00, multiplicand} * {8'h00, data};
          OFF_DVND_LO:   dividend[7:0] = data;
          OFF_DVND_HI:   dividend[15:8] = data;
          OFF_DIV_START: begin
            if (data == 8'h00) begin
              quotient          = DIV_ZERO_QUO;
              product_remainder = dividend;
            end else begin
              quotient          = dividend / {8'h00, data};
              product_remainder = dividend % {8'h00, data};
            end
          end
          OFF_FAST_SEL:  fast_select = data[0];
          default: ;
        endcase
      end else begin
        case (req.reg_offset)
          OFF_QUO_LO: predicted.read_data = quotient[7:0];
          OFF_QUO_HI: predicted.read_data = quotient[15:8];
          OFF_PRR_LO: predicted.read_data = product_remainder[7:0];
          OFF_PRR_HI: predicted.read_data = product_remainder[15:8];
          default: ;
        endcase
      end
      predicted.io_port_out     = io_port;
      predicted.fast_mem_select = fast_select;
      pending_results.push_back(predicted);
    endfunction

    function void compare_field(string field, logic [7:0] wanted, logic [7:0] seen);
      if (seen !== wanted) begin
        $display("%0t: %s expected %h, got %h", $time, field, wanted, seen);
        errors++;
      end
    endfunction

    // Compares one strobed result with the oldest prediction.
    function void check_result(result_t got);
      result_t wanted;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        errors++;
      end else begin
        wanted = pending_results.pop_front();
        compare_field("read_data", wanted.read_data, got.read_data);
        compare_field("io_port_out", wanted.io_port_out, got.io_port_out);
        compare_field("fast_mem_select", {7'b0, wanted.fast_mem_select},
                      {7'b0, got.fast_mem_select});
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  register_model model = new();
  int            sent_count = 0;
  bit            no_idle = 1'b0;

  mul_div_io_registers i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Every strobed result is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      model.check_result(result);
    end
  end

  // Offers one request after a random gap and waits until the block takes it.
  task automatic send(input request_t req);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    model.note_access(req);
    sent_count++;
  endtask

  task automatic access(input logic op, input logic [4:0] offset, input logic [7:0] data,
                        input logic [7:0] bus);
    request_t req;
    req.opcode        = op;
    req.reg_offset    = offset;
    req.write_data    = data;
    req.open_bus_byte = bus;
    send(req);
  endtask

  // Holds the bus quiet until every outstanding result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (model.pending_results.size() != 0);
  endtask

  // Operand bytes lean toward the edges of the range.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  // Main sequence: reset, directed accesses, random access sequences, wrap-up.
  initial begin
    int kind;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset values, open-bus reads and the port and select registers.
    access(OP_READ, OFF_QUO_LO, 8'h00, 8'h00);
    access(OP_READ, OFF_PRR_HI, 8'hFF, 8'hFF);
    access(OP_READ, OFF_UNMAPPED_LO, 8'h00, 8'hA5);
    access(OP_WRITE, OFF_IO_PORT, 8'h00, 8'h5A);
    access(OP_WRITE, OFF_FAST_SEL, 8'hFF, 8'h00);
    access(OP_WRITE, OFF_FAST_SEL, 8'hFE, 8'hFF);
    // Largest and zero products.
    access(OP_WRITE, OFF_MCAND, 8'hFF, 8'h00);
    access(OP_WRITE, OFF_MUL_START, 8'hFF, 8'h00);
    access(OP_READ, OFF_PRR_LO, 8'h00, 8'h00);
    access(OP_READ, OFF_PRR_HI, 8'h00, 8'h00);
    access(OP_WRITE, OFF_MUL_START, 8'h00, 8'hFF);
    access(OP_READ, OFF_PRR_LO, 8'hFF, 8'hFF);
    // Full-scale divide by one, then a divide by zero.
    access(OP_WRITE, OFF_DVND_LO, 8'hFF, 8'h00);
    access(OP_WRITE, OFF_DVND_HI, 8'hFF, 8'h00);
    access(OP_WRITE, OFF_DIV_START, 8'h01, 8'h00);
    access(OP_READ, OFF_QUO_HI, 8'h00, 8'h00);
    access(OP_READ, OFF_PRR_LO, 8'h00, 8'hFF);
    access(OP_WRITE, OFF_DIV_START, 8'h00, 8'h00);
    access(OP_READ, OFF_QUO_LO, 8'h00, 8'h00);
    access(OP_READ, OFF_PRR_HI, 8'h00, 8'h00);
    // Writes to result registers are ignored; write-only offsets read as open bus.
    access(OP_WRITE, OFF_QUO_LO, 8'h00, 8'h3C);
    access(OP_READ, OFF_QUO_LO, 8'h00, 8'h00);
    access(OP_READ, OFF_DIV_START, 8'h00, 8'hC3);
    access(OP_READ, OFF_UNMAPPED_HI, 8'hFF, 8'h00);
    access(OP_WRITE, OFF_IO_PORT, 8'hFF, 8'h00);
    drain();

    // Random multiply and divide sequences mixed with port writes and noise.
    while (sent_count < RANDOM_ACCESSES + 25) begin
      no_idle = ($urandom_range(0, 5) == 0);
      kind    = $urandom_range(0, 9);
      if (kind <= 2) begin
        access(OP_WRITE, OFF_MCAND, pick_byte(), 8'($urandom));
        access(OP_WRITE, OFF_MUL_START, pick_byte(), 8'($urandom));
        access(OP_READ, OFF_PRR_LO, 8'($urandom), 8'($urandom));
        access(OP_READ, OFF_PRR_HI, 8'($urandom), 8'($urandom));
      end else if (kind <= 5) begin
        if ($urandom_range(0, 3) != 0) begin
          access(OP_WRITE, OFF_DVND_LO, pick_byte(), 8'($urandom));
        end
        if ($urandom_range(0, 3) != 0) begin
          access(OP_WRITE, OFF_DVND_HI, pick_byte(), 8'($urandom));
        end
        access(OP_WRITE, OFF_DIV_START, pick_byte(), 8'($urandom));
        access(OP_READ, OFF_QUO_LO, 8'($urandom), 8'($urandom));
        access(OP_READ, OFF_QUO_HI, 8'($urandom), 8'($urandom));
        access(OP_READ, OFF_PRR_LO, 8'($urandom), 8'($urandom));
        access(OP_READ, OFF_PRR_HI, 8'($urandom), 8'($urandom));
      end else if (kind == 6) begin
        access(OP_WRITE, ($urandom_range(0, 1) == 0) ? OFF_IO_PORT : OFF_FAST_SEL,
               8'($urandom), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          access(1'($urandom), 5'($urandom), 8'($urandom), 8'($urandom));
        end
      end
      if ($urandom_range(0, 49) == 0) begin
        drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (model.errors == 0 && model.pending_results.size() == 0) begin
      $display("mul_div_io_registers: match");
    end else begin
      $display("mul_div_io_registers: mismatch");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("mul_div_io_registers: mismatch");
    $finish;
  end

endmodule
